@@ rtl/tcpop_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tcpop_pkg;

    // option area limits
    localparam int unsigned OPT_AREA_MAX = 40;
    localparam int unsigned AREA_CNT_W   = 6;

    // option kinds
    localparam logic [7:0] KIND_EOL      = 8'd0;
    localparam logic [7:0] KIND_NOP      = 8'd1;
    localparam logic [7:0] KIND_MSS      = 8'd2;
    localparam logic [7:0] KIND_WSCALE   = 8'd3;
    localparam logic [7:0] KIND_SACKPERM = 8'd4;
    localparam logic [7:0] KIND_SACK     = 8'd5;
    localparam logic [7:0] KIND_TS       = 8'd8;

    // option lengths
    localparam logic [7:0] LEN_MIN      = 8'd2;
    localparam logic [7:0] LEN_SACKPERM = 8'd2;
    localparam logic [7:0] LEN_WSCALE   = 8'd3;
    localparam logic [7:0] LEN_MSS      = 8'd4;
    localparam logic [7:0] LEN_TS       = 8'd10;
    localparam logic [7:0] LEN_SACK_MIN = 8'd10;

    // shift count ceiling
    localparam logic [7:0] WSCALE_MAX = 8'd14;

    // timestamp body bytes that form tsval
    localparam logic [5:0] TS_VAL_BYTES = 6'd4;

    // flag bit positions
    localparam int unsigned FL_SACKPERM = 0;
    localparam int unsigned FL_WSCALE   = 1;
    localparam int unsigned FL_MSS      = 2;
    localparam int unsigned FL_SACK     = 3;
    localparam int unsigned FL_TS       = 4;

    typedef enum logic [2:0] {
        PH_KIND = 3'b001,
        PH_SIZE = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic        sack_permitted;
        logic        wscale_present;
        logic [3:0]  wscale_value;
        logic        mss_present;
        logic [15:0] mss_value;
        logic        sack_present;
        logic [31:0] sack_edge;
        logic        ts_present;
        logic [31:0] ts_value;
        logic        stopped_early;
    } out_beat_t;

    typedef struct packed {
        phase_t                  phase;
        logic [7:0]              kind;
        logic [7:0]              size;
        logic [5:0]              body_idx;
        logic [AREA_CNT_W-1:0]   bytes_left;
        logic [31:0]             word;
        logic [4:0]              flags;
        logic [3:0]              scale;
        logic [15:0]             mss;
        logic [31:0]             right_edge;
        logic [31:0]             tsval;
        logic                    halted;
        logic [31:0]             pend_edge;
        logic                    pend_adv;
    } parse_state_t;

    // state at reset and at the start of every header
    function automatic parse_state_t idle_state();
        parse_state_t s;
        s            = '0;
        s.phase      = PH_KIND;
        s.bytes_left = AREA_CNT_W'(OPT_AREA_MAX);
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tcpop_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tcpop_step (
    input  wire tcpop_pkg::parse_state_t cur,
    input  wire tcpop_pkg::in_beat_t     beat,
    output tcpop_pkg::parse_state_t      nxt,
    output tcpop_pkg::out_beat_t         summary
);

    logic       commit;
    logic [7:0] b;
    logic [7:0] idx_inc;
    logic [7:0] body_end;
    logic [31:0] serial_diff;

    assign b        = beat.opt_byte;
    assign idx_inc  = {2'b00, cur.body_idx} + 8'd1;
    assign body_end = cur.size - tcpop_pkg::LEN_MIN;

    // walk one option byte, then apply a finished option
    always_comb
    begin
        nxt         = cur;
        commit      = 1'b0;
        serial_diff = '0;
        if (!cur.halted)
        begin
            if (cur.bytes_left == '0)
            begin
                nxt.halted = 1'b1;
            end
            else
            begin
                nxt.bytes_left = cur.bytes_left - 1'b1;
                case (cur.phase)
                    tcpop_pkg::PH_KIND:
                    begin
                        if (b == tcpop_pkg::KIND_EOL)
                        begin
                            nxt.halted = 1'b1;
                        end
                        else if (b != tcpop_pkg::KIND_NOP)
                        begin
                            nxt.kind  = b;
                            nxt.phase = tcpop_pkg::PH_SIZE;
                        end
                    end
                    tcpop_pkg::PH_SIZE:
                    begin
                        nxt.size = b;
                        if (b < tcpop_pkg::LEN_MIN)
                        begin
                            nxt.halted = 1'b1;
                            nxt.phase  = tcpop_pkg::PH_KIND;
                        end
                        else
                        begin
                            nxt.body_idx  = '0;
                            nxt.word      = '0;
                            nxt.pend_edge = cur.right_edge;
                            nxt.pend_adv  = 1'b0;
                            if (b == tcpop_pkg::LEN_MIN)
                                commit = 1'b1;
                            else
                                nxt.phase = tcpop_pkg::PH_BODY;
                        end
                    end
                    tcpop_pkg::PH_BODY:
                    begin
                        // timestamp keeps only the first four body bytes
                        if (cur.kind != tcpop_pkg::KIND_TS
                            || cur.body_idx < tcpop_pkg::TS_VAL_BYTES)
                            nxt.word = {cur.word[23:0], b};
                        // sack block right edge, serial-number compare
                        serial_diff = cur.pend_edge - nxt.word;
                        if (cur.kind == tcpop_pkg::KIND_SACK && cur.body_idx[2:0] == 3'b111
                            && serial_diff[31])
                        begin
                            nxt.pend_edge = nxt.word;
                            nxt.pend_adv  = 1'b1;
                        end
                        nxt.body_idx = cur.body_idx + 6'd1;
                        if (idx_inc == body_end)
                            commit = 1'b1;
                    end
                    default:
                    begin
                        nxt.phase = tcpop_pkg::PH_KIND;
                    end
                endcase
            end
        end

        // record a complete option
        if (commit)
        begin
            nxt.phase = tcpop_pkg::PH_KIND;
            if (nxt.kind == tcpop_pkg::KIND_SACKPERM && nxt.size == tcpop_pkg::LEN_SACKPERM)
            begin
                nxt.flags[tcpop_pkg::FL_SACKPERM] = 1'b1;
            end
            else if (nxt.kind == tcpop_pkg::KIND_WSCALE && nxt.size == tcpop_pkg::LEN_WSCALE)
            begin
                nxt.scale = (nxt.word[7:0] > tcpop_pkg::WSCALE_MAX)
                          ? tcpop_pkg::WSCALE_MAX[3:0] : nxt.word[3:0];
                nxt.flags[tcpop_pkg::FL_WSCALE] = 1'b1;
            end
            else if (nxt.kind == tcpop_pkg::KIND_MSS && nxt.size == tcpop_pkg::LEN_MSS)
            begin
                nxt.mss = nxt.word[15:0];
                nxt.flags[tcpop_pkg::FL_MSS] = 1'b1;
            end
            else if (nxt.kind == tcpop_pkg::KIND_SACK && nxt.size >= tcpop_pkg::LEN_SACK_MIN
                     && nxt.size[2:0] == 3'b010)
            begin
                if (nxt.pend_adv)
                begin
                    nxt.right_edge = nxt.pend_edge;
                    nxt.flags[tcpop_pkg::FL_SACK] = 1'b1;
                end
            end
            else if (nxt.kind == tcpop_pkg::KIND_TS && nxt.size == tcpop_pkg::LEN_TS)
            begin
                nxt.tsval = nxt.word;
                nxt.flags[tcpop_pkg::FL_TS] = 1'b1;
            end
        end
    end

    // summary as seen after this byte
    always_comb
    begin
        summary.sack_permitted = nxt.flags[tcpop_pkg::FL_SACKPERM];
        summary.wscale_present = nxt.flags[tcpop_pkg::FL_WSCALE];
        summary.wscale_value   = nxt.flags[tcpop_pkg::FL_WSCALE] ? nxt.scale : 4'd0;
        summary.mss_present    = nxt.flags[tcpop_pkg::FL_MSS];
        summary.mss_value      = nxt.flags[tcpop_pkg::FL_MSS] ? nxt.mss : 16'd0;
        summary.sack_present   = nxt.flags[tcpop_pkg::FL_SACK];
        summary.sack_edge      = nxt.flags[tcpop_pkg::FL_SACK] ? nxt.right_edge : 32'd0;
        summary.ts_present     = nxt.flags[tcpop_pkg::FL_TS];
        summary.ts_value       = nxt.flags[tcpop_pkg::FL_TS] ? nxt.tsval : 32'd0;
        summary.stopped_early  = nxt.halted || (nxt.phase != tcpop_pkg::PH_KIND);
    end

endmodule

`default_nettype wire

@@ rtl/tcp_option_parser.sv @@
// TCP option area parser.
// Input channel byte_*: one option byte per beat, last_byte set on the
// final byte of a header. Output channel sum_*: one summary beat per
// header, produced for the byte marked last (MSS, window scale, SACK
// permitted, furthest SACK right edge, timestamp value, early stop flag).
// Throughput: one byte per cycle while no pending summary is held by
// sum_stall. Each byte goes through an input register and one pass of
// decode logic that updates the parse state. The summary for the last
// byte is registered in the output register and waits there until taken.
// At most OPT_AREA_MAX bytes are parsed per header; later bytes until
// the last mark are dropped and flag an early stop.
// Reset: parse state returns to the start of a header, both registers
// are empty, byte_stall is low. The parse state also returns to that
// start after each last byte.
// Stall: while sum_stall holds a pending summary, the byte in the
// input register waits and byte_stall rises; a summary beat and its
// payload hold until taken.
`timescale 1ns / 1ps
`default_nettype none

module tcp_option_parser (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  byte_valid,
    output logic                 byte_stall,
    input  wire tcpop_pkg::in_beat_t byte_data,
    output logic                 sum_valid,
    input  wire                  sum_stall,
    output tcpop_pkg::out_beat_t sum_data
);

    logic                    in_valid_reg;
    logic                    in_valid_next;
    tcpop_pkg::in_beat_t     in_beat_reg;
    tcpop_pkg::parse_state_t state_reg;
    tcpop_pkg::parse_state_t state_next;
    tcpop_pkg::parse_state_t step_state;
    tcpop_pkg::out_beat_t    step_summary;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    tcpop_pkg::out_beat_t    out_beat_reg;
    logic                    advance;
    logic                    accept;

    // handshake control
    assign advance    = in_valid_reg && (!out_valid_reg || !sum_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = (advance && in_beat_reg.last_byte)
                          ? 1'b1 : (out_valid_reg && sum_stall);

    // per-byte decode
    tcpop_step u_step (
        .cur     (state_reg),
        .beat    (in_beat_reg),
        .nxt     (step_state),
        .summary (step_summary)
    );

    // state update, back to the header start after the last byte
    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            if (in_beat_reg.last_byte)
                state_next = tcpop_pkg::idle_state();
            else
                state_next = step_state;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= tcpop_pkg::idle_state();
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            in_beat_reg <= byte_data;
        if (advance && in_beat_reg.last_byte)
            out_beat_reg <= step_summary;
    end

    assign sum_valid = out_valid_reg;
    assign sum_data  = out_beat_reg;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tcpop_pkg::*;

    localparam int unsigned BYTE_TARGET = 1250;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned IDLE_PCT    = 24;

    typedef struct {
        in_beat_t beat;
        bit       drain;
    } stim_t;

    logic      clk;
    logic      rst_n      = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_beat_t  byte_data  = '0;
    logic      sum_valid;
    logic      sum_stall  = 1'b0;
    out_beat_t sum_data;

    tcp_option_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .sum_valid  (sum_valid),
        .sum_stall  (sum_stall),
        .sum_data   (sum_data)
    );

    // pending input beats and expected summaries
    stim_t      byte_q[$];
    out_beat_t  summary_q[$];
    logic [7:0] hdr[$];
    logic [7:0] opt_tmp[$];
    logic [31:0] last_edge;

    bit          byte_taken = 1'b0;
    int unsigned taken_cnt  = 0;
    int unsigned err_cnt    = 0;
    int unsigned cycle_cnt  = 0;
    bit          quiet;

    // parser shadow state
    phase_t      ph;
    logic [7:0]  opt_kind;
    logic [7:0]  opt_len;
    logic [5:0]  body_pos;
    int unsigned area_left;
    logic [31:0] acc_word;
    logic        got_sackperm, got_wscale, got_mss, got_sack, got_ts;
    logic [3:0]  ws_shift;
    logic [15:0] mss_val;
    logic [31:0] right_edge;
    logic [31:0] ts_val;
    logic        halt;
    logic [31:0] cand_edge;
    logic        cand_adv;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // no random idling on either side for a long stretch of the run
    assign quiet = (taken_cnt >= 500) && (taken_cnt < 800);

    task automatic clear_parse();
        ph           = PH_KIND;
        opt_kind     = '0;
        opt_len      = '0;
        body_pos     = '0;
        area_left    = OPT_AREA_MAX;
        acc_word     = '0;
        got_sackperm = 1'b0;
        got_wscale   = 1'b0;
        got_mss      = 1'b0;
        got_sack     = 1'b0;
        got_ts       = 1'b0;
        ws_shift     = '0;
        mss_val      = '0;
        right_edge   = '0;
        ts_val       = '0;
        halt         = 1'b0;
        cand_edge    = '0;
        cand_adv     = 1'b0;
    endtask

    // an option takes effect once its last body byte is in
    task automatic close_option();
        if (opt_kind == KIND_SACKPERM && opt_len == LEN_SACKPERM)
        begin
            got_sackperm = 1'b1;
        end
        else if (opt_kind == KIND_WSCALE && opt_len == LEN_WSCALE)
        begin
            ws_shift   = (acc_word[7:0] > WSCALE_MAX) ? WSCALE_MAX[3:0] : acc_word[3:0];
            got_wscale = 1'b1;
        end
        else if (opt_kind == KIND_MSS && opt_len == LEN_MSS)
        begin
            mss_val = acc_word[15:0];
            got_mss = 1'b1;
        end
        else if (opt_kind == KIND_SACK && opt_len >= LEN_SACK_MIN
                 && ((opt_len - LEN_MIN) & 8'h07) == 8'h00)
        begin
            if (cand_adv)
            begin
                right_edge = cand_edge;
                got_sack   = 1'b1;
            end
        end
        else if (opt_kind == KIND_TS && opt_len == LEN_TS)
        begin
            ts_val = acc_word;
            got_ts = 1'b1;
        end
        ph = PH_KIND;
    endtask

    // advance the shadow parser by one accepted beat
    task automatic parse_option_byte(input in_beat_t b);
        logic [7:0]  v;
        logic [31:0] diff;
        out_beat_t   s;
        v = b.opt_byte;
        if (!halt)
        begin
            if (area_left == 0)
            begin
                halt = 1'b1;
            end
            else
            begin
                area_left--;
                case (ph)
                    PH_KIND:
                    begin
                        if (v == KIND_EOL)
                        begin
                            halt = 1'b1;
                        end
                        else if (v != KIND_NOP)
                        begin
                            opt_kind = v;
                            ph       = PH_SIZE;
                        end
                    end
                    PH_SIZE:
                    begin
                        opt_len = v;
                        if (v < LEN_MIN)
                        begin
                            halt = 1'b1;
                            ph   = PH_KIND;
                        end
                        else
                        begin
                            body_pos  = '0;
                            acc_word  = '0;
                            cand_edge = right_edge;
                            cand_adv  = 1'b0;
                            if (v == LEN_MIN)
                                close_option();
                            else
                                ph = PH_BODY;
                        end
                    end
                    default:
                    begin
                        if (opt_kind != KIND_TS || body_pos < TS_VAL_BYTES)
                            acc_word = {acc_word[23:0], v};
                        // serial-number compare on each right edge
                        if (opt_kind == KIND_SACK && body_pos[2:0] == 3'd7)
                        begin
                            diff = cand_edge - acc_word;
                            if (diff[31])
                            begin
                                cand_edge = acc_word;
                                cand_adv  = 1'b1;
                            end
                        end
                        if (int'(body_pos) + 1 == int'(opt_len) - 2)
                        begin
                            body_pos = body_pos + 6'd1;
                            close_option();
                        end
                        else
                        begin
                            body_pos = body_pos + 6'd1;
                        end
                    end
                endcase
            end
        end
        if (b.last_byte)
        begin
            s.sack_permitted = got_sackperm;
            s.wscale_present = got_wscale;
            s.wscale_value   = got_wscale ? ws_shift : 4'd0;
            s.mss_present    = got_mss;
            s.mss_value      = got_mss ? mss_val : 16'd0;
            s.sack_present   = got_sack;
            s.sack_edge      = got_sack ? right_edge : 32'd0;
            s.ts_present     = got_ts;
            s.ts_value       = got_ts ? ts_val : 32'd0;
            s.stopped_early  = halt || (ph != PH_KIND);
            summary_q.push_back(s);
            clear_parse();
        end
    endtask

    // header bytes into the beat queue, last mark on the final one
    task automatic push_header(input bit drain);
        stim_t e;
        for (int i = 0; i < hdr.size(); i++)
        begin
            e.beat.opt_byte  = hdr[i];
            e.beat.last_byte = (i == hdr.size() - 1);
            e.drain          = drain && (i == 0);
            byte_q.push_back(e);
        end
        hdr.delete();
    endtask

    task automatic push_word(input logic [31:0] w);
        opt_tmp.push_back(w[31:24]);
        opt_tmp.push_back(w[23:16]);
        opt_tmp.push_back(w[15:8]);
        opt_tmp.push_back(w[7:0]);
    endtask

    // one random option into opt_tmp
    task automatic build_option();
        int          n;
        logic [31:0] re;
        logic [7:0]  k;
        opt_tmp.delete();
        case ($urandom_range(9))
            0: opt_tmp.push_back(KIND_NOP);
            1:
            begin
                opt_tmp = '{KIND_MSS, LEN_MSS};
                opt_tmp.push_back(8'($urandom_range(255)));
                opt_tmp.push_back(8'($urandom_range(255)));
            end
            2:
            begin
                opt_tmp = '{KIND_WSCALE, LEN_WSCALE};
                opt_tmp.push_back($urandom_range(1) ? 8'($urandom_range(12, 16))
                                                    : 8'($urandom_range(255)));
            end
            3: opt_tmp = '{KIND_SACKPERM, LEN_SACKPERM};
            4, 5:
            begin
                n = $urandom_range(1, 4);
                opt_tmp = '{KIND_SACK};
                opt_tmp.push_back(8'(2 + 8 * n));
                repeat (n)
                begin
                    push_word($urandom);
                    case ($urandom_range(4))
                        0: re = 32'h8000_0000;
                        1: re = 32'h7fff_ffff;
                        2: re = last_edge + $urandom_range(1, 4);
                        3: re = last_edge ^ 32'h8000_0000;
                        default: re = $urandom;
                    endcase
                    last_edge = re;
                    push_word(re);
                end
            end
            6:
            begin
                opt_tmp = '{KIND_TS, LEN_TS};
                push_word($urandom);
                push_word($urandom);
            end
            7:
            begin
                // known kind with a random length, often wrong or odd
                case ($urandom_range(4))
                    0: k = KIND_MSS;
                    1: k = KIND_WSCALE;
                    2: k = KIND_SACKPERM;
                    3: k = KIND_SACK;
                    default: k = KIND_TS;
                endcase
                n = $urandom_range(2, 14);
                opt_tmp.push_back(k);
                opt_tmp.push_back(8'(n));
                repeat (n - 2) opt_tmp.push_back(8'($urandom_range(255)));
            end
            default:
            begin
                n = $urandom_range(2, 10);
                opt_tmp.push_back(8'($urandom_range(6, 255)));
                opt_tmp.push_back(8'(n));
                repeat (n - 2) opt_tmp.push_back(8'($urandom_range(255)));
            end
        endcase
    endtask

    // stimulus and end of run
    initial
    begin
        int sel;
        int cut;
        clear_parse();
        last_edge = '0;

        // every known option but SACK at field extremes, all complete
        hdr = '{8'h02, 8'h04, 8'hff, 8'hff, 8'h03, 8'h03, 8'hff, 8'h04, 8'h02,
                8'h01, 8'h08, 8'h0a, 8'h80, 8'h00, 8'h00, 8'h01, 8'haa, 8'hbb,
                8'hcc, 8'hdd};
        push_header(1'b0);
        // length below two
        hdr = '{8'h06, 8'h01};
        push_header(1'b0);
        // end of list then a dropped byte
        hdr = '{8'h00, 8'h02};
        push_header(1'b0);
        // header cut inside an option body
        hdr = '{8'h02, 8'h04, 8'h12};
        push_header(1'b0);
        // single byte header ending after a kind
        hdr = '{8'hff};
        push_header(1'b0);

        // random headers, the first after a full drain
        sel = 0;
        while (byte_q.size() < BYTE_TARGET + 30)
        begin
            sel = $urandom_range(99);
            if (sel < 65)
            begin
                // well-formed list within the area
                cut = $urandom_range(1, 40);
                repeat (8)
                begin
                    build_option();
                    if (hdr.size() + opt_tmp.size() <= cut)
                        foreach (opt_tmp[i]) hdr.push_back(opt_tmp[i]);
                end
                if (hdr.size() < 40 && $urandom_range(3) == 0)
                begin
                    hdr.push_back(KIND_EOL);
                    repeat ($urandom_range(3)) hdr.push_back(8'($urandom_range(255)));
                end
                if (hdr.size() == 0)
                    hdr.push_back(KIND_NOP);
            end
            else if (sel < 80)
            begin
                // well-formed list cut short
                repeat (3)
                begin
                    build_option();
                    foreach (opt_tmp[i]) hdr.push_back(opt_tmp[i]);
                end
                cut = $urandom_range(1, hdr.size());
                while (hdr.size() > cut) void'(hdr.pop_back());
            end
            else if (sel < 92)
            begin
                // noise
                repeat ($urandom_range(1, 12))
                    hdr.push_back($urandom_range(1) ? 8'($urandom_range(0, 10))
                                                    : 8'($urandom_range(255)));
            end
            else
            begin
                // runs past the option area
                cut = $urandom_range(41, 60);
                while (hdr.size() < cut)
                begin
                    build_option();
                    foreach (opt_tmp[i]) hdr.push_back(opt_tmp[i]);
                end
            end
            push_header(byte_q.size() < 60 || $urandom_range(99) < 2);
        end

        do @(posedge clk); while (byte_q.size() != 0 || byte_valid);
        while (summary_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // driver: byte beats from the queue, held until taken
    always @(negedge clk)
    begin
        if (rst_n && !(byte_valid && !byte_taken))
        begin
            if (byte_q.size() == 0)
            begin
                byte_valid <= 1'b0;
            end
            else if (byte_q[0].drain && summary_q.size() != 0)
            begin
                byte_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(99) < IDLE_PCT)
            begin
                byte_valid <= 1'b0;
            end
            else
            begin
                byte_data  <= byte_q[0].beat;
                byte_valid <= 1'b1;
                void'(byte_q.pop_front());
            end
        end
    end

    // summary side back-pressure
    always @(negedge clk)
    begin
        sum_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // monitor: check summaries, predict on accepted byte beats
    always @(posedge clk)
    begin
        out_beat_t exp_sum;
        if (rst_n && sum_valid && !sum_stall)
        begin
            if (summary_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected summary beat %h", sum_data);
            end
            else
            begin
                exp_sum = summary_q.pop_front();
                if (sum_data !== exp_sum)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("summary mismatch: expected %h actual %h",
                                 exp_sum, sum_data);
                end
            end
        end
        if (rst_n && byte_valid && !byte_stall)
        begin
            byte_taken = 1'b1;
            taken_cnt++;
            parse_option_byte(byte_data);
        end
        else
        begin
            byte_taken = 1'b0;
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
